// ===== design/ntd_pkg.sv =====
// Shared constants and codes for the nearest target direction block.
package ntd_pkg;

  localparam int MAX_TARGETS_DEF = 64;
  localparam int COORD_BITS_DEF  = 10;

  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 6;
  localparam int DIR_W    = 3;
  localparam int COUNT_W  = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LIVE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_INIT   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_RECALC = 2'd3;

  localparam logic [DIR_W-1:0] HDG_NONE  = 3'd0;
  localparam logic [DIR_W-1:0] HDG_NORTH = 3'd1;
  localparam logic [DIR_W-1:0] HDG_SOUTH = 3'd2;
  localparam logic [DIR_W-1:0] HDG_EAST  = 3'd3;
  localparam logic [DIR_W-1:0] HDG_WEST  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_X       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_Y       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 2'd2;

  // squared search limits: 99999^2 for the initial search, 9999^2 for recalc
  localparam int LIMIT_W = 34;
  localparam logic [LIMIT_W-1:0] INIT_LIMIT_SQ   = 34'd9999800001;
  localparam logic [LIMIT_W-1:0] RECALC_LIMIT_SQ = 34'd99980001;

endpackage

// ===== design/ntd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ntd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/nearest_target_direction_core.sv =====
// Nearest target direction finder: target table, search sequencer and datapath.
//
// Usage: one item channel (item_valid/item_ready) carries actions, one result
// channel (result_valid/result_ready) returns found, nearest_index, direction.
// Load and set-live transactions leave the sequencer idle and give no result.
// Initial search and recalc walk the table one entry per cycle through the
// coordinate and distance RAM read ports. Once the walk has drained the
// three-stage distance pipeline (initial) or the one-stage pipeline (recalc),
// the sequencer passes its fetch and direction states and result_valid rises.
// A recalc while this node is itself a target skips the walk. item_ready is
// high only while the sequencer is idle and returns with the result, so a new
// search is not accepted before the last one has produced its result. A pending
// result does not block the next item, but a search that finishes while the
// previous result is still waiting holds until the receiver takes it. Config
// writes (cfg_write/cfg_index/cfg_data) take effect at once and belong to idle
// periods. Synchronous reset clears node_x/node_y/target_count, live, excl,
// result_valid and the sequencer; RAMs and result outputs are not cleared.
module nearest_target_direction_core #(
  parameter int MAX_TARGETS = ntd_pkg::MAX_TARGETS_DEF,
  parameter int COORD_BITS  = ntd_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [ntd_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [((COORD_BITS > 7) ? COORD_BITS : 7)-1:0] cfg_data,
  input  logic                                    item_valid,
  output logic                                    item_ready,
  input  logic [ntd_pkg::ACTION_W-1:0]            action,
  input  logic [ntd_pkg::INDEX_W-1:0]             entry_index,
  input  logic [COORD_BITS-1:0]                   target_x,
  input  logic [COORD_BITS-1:0]                   target_y,
  input  logic                                    is_live,
  input  logic                                    self_is_target,
  output logic                                    result_valid,
  input  logic                                    result_ready,
  output logic                                    found,
  output logic [ntd_pkg::INDEX_W-1:0]             nearest_index,
  output logic [ntd_pkg::DIR_W-1:0]               direction
);
  import ntd_pkg::*;

  localparam int IDX_W  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_W  = $clog2(MAX_TARGETS + 1);
  localparam int NW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DW     = SQ_W + 1;
  localparam int BEST_W = (DW > LIMIT_W) ? DW : LIMIT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_DIR   = 2'd3;

  logic [1:0]             state;
  logic [COORD_BITS-1:0]  node_x;
  logic [COORD_BITS-1:0]  node_y;
  logic [COUNT_W-1:0]     target_count;
  logic [MAX_TARGETS-1:0] live;
  logic [MAX_TARGETS-1:0] excl;
  logic [CNT_W-1:0]       cnt;
  logic                   r0_v, s1_v, s2_v;
  logic [IDX_W-1:0]       r0_idx, s1_idx, s2_idx;
  logic [COORD_BITS-1:0]  dx1, dy1;
  logic [SQ_W-1:0]        sq_x, sq_y;
  logic [BEST_W-1:0]      best;
  logic [IDX_W-1:0]       best_i;
  logic                   found_r;
  logic                   mode_init;

  logic                   acc;
  logic                   in_range;
  logic [IDX_W-1:0]       wr_idx;
  logic [NW-1:0]          n_used;
  logic                   issue;
  logic                   walk_done;
  logic                   out_free;
  logic [IDX_W-1:0]       rd_addr;
  logic [SQ_W-1:0]        xy_q;
  logic [DW-1:0]          dist_q;
  logic [DW-1:0]          sum;
  logic                   rec_hit, rec_take, rec_mark, ini_take;
  logic [COORD_BITS-1:0]  bx, by, r0x, r0y, adx, ady;
  logic [DIR_W-1:0]       dir_calc;

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  assign acc        = item_valid && item_ready;
  assign item_ready = (state == S_IDLE);
  assign in_range   = (32'(entry_index) < 32'(MAX_TARGETS));
  assign wr_idx     = IDX_W'(entry_index);
  assign n_used     = (NW'(target_count) > NW'(MAX_TARGETS)) ? NW'(MAX_TARGETS)
                                                             : NW'(target_count);
  assign issue      = (state == S_WALK) && (NW'(cnt) < n_used);
  assign walk_done  = (state == S_WALK) && !issue && !r0_v && !s1_v && !s2_v;
  assign out_free   = !result_valid || result_ready;
  assign rd_addr    = (state == S_WALK) ? cnt[IDX_W-1:0] : best_i;

  ntd_ram #(.WIDTH(SQ_W), .DEPTH(MAX_TARGETS)) u_xy_ram (
    .clk   (clk),
    .we    (acc && action == ACT_LOAD && in_range),
    .waddr (wr_idx),
    .wdata ({target_y, target_x}),
    .raddr (rd_addr),
    .rdata (xy_q)
  );

  ntd_ram #(.WIDTH(DW), .DEPTH(MAX_TARGETS)) u_dist_ram (
    .clk   (clk),
    .we    (s2_v),
    .waddr (s2_idx),
    .wdata (sum),
    .raddr (rd_addr),
    .rdata (dist_q)
  );

  assign r0x      = xy_q[COORD_BITS-1:0];
  assign r0y      = xy_q[SQ_W-1:COORD_BITS];
  assign sum      = DW'(sq_x) + DW'(sq_y);
  assign rec_hit  = r0_v && !mode_init && !excl[r0_idx] && (BEST_W'(dist_q) < best);
  assign rec_take = rec_hit && live[r0_idx];
  assign rec_mark = rec_hit && !live[r0_idx];
  assign ini_take = s2_v && (BEST_W'(sum) < best);

  assign bx  = r0x;
  assign by  = r0y;
  assign adx = abs_diff(node_x, bx);
  assign ady = abs_diff(node_y, by);

  always_comb begin
    if (!found_r || (mode_init && best == '0)) begin
      dir_calc = HDG_NONE;
    end else if (adx >= ady) begin
      dir_calc = (node_x < bx) ? HDG_EAST : HDG_WEST;
    end else begin
      dir_calc = (node_y < by) ? HDG_SOUTH : HDG_NORTH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      node_x       <= '0;
      node_y       <= '0;
      target_count <= '0;
      live         <= '0;
      excl         <= '0;
      cnt          <= '0;
      r0_v         <= 1'b0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_NODE_X:       node_x       <= COORD_BITS'(cfg_data);
          REG_NODE_Y:       node_y       <= COORD_BITS'(cfg_data);
          REG_TARGET_COUNT: target_count <= COUNT_W'(cfg_data);
          default: ;
        endcase
      end

      r0_v <= issue;
      s1_v <= r0_v && mode_init;
      s2_v <= s1_v;
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (s2_v) begin
        excl[s2_idx] <= 1'b0;
      end
      if (rec_mark) begin
        excl[r0_idx] <= 1'b1;
      end

      if (state == S_DIR && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (acc) begin
            case (action)
              ACT_LIVE: begin
                if (in_range) begin
                  live[wr_idx] <= is_live;
                end
              end
              ACT_INIT: begin
                cnt   <= '0;
                state <= S_WALK;
              end
              ACT_RECALC: begin
                cnt   <= '0;
                state <= self_is_target ? S_DIR : S_WALK;
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (walk_done) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_DIR;
        end
        S_DIR: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r0_idx <= cnt[IDX_W-1:0];
    s1_idx <= r0_idx;
    s2_idx <= s1_idx;
    dx1    <= abs_diff(node_x, r0x);
    dy1    <= abs_diff(node_y, r0y);
    sq_x   <= SQ_W'(dx1) * SQ_W'(dx1);
    sq_y   <= SQ_W'(dy1) * SQ_W'(dy1);

    if (acc && (action == ACT_INIT || action == ACT_RECALC)) begin
      mode_init <= (action == ACT_INIT);
      best      <= (action == ACT_INIT) ? BEST_W'(INIT_LIMIT_SQ) : BEST_W'(RECALC_LIMIT_SQ);
      best_i    <= '0;
      found_r   <= 1'b0;
    end else if (ini_take) begin
      best    <= BEST_W'(sum);
      best_i  <= s2_idx;
      found_r <= 1'b1;
    end else if (rec_take) begin
      best    <= BEST_W'(dist_q);
      best_i  <= r0_idx;
      found_r <= 1'b1;
    end

    if (state == S_DIR && out_free) begin
      found         <= found_r;
      nearest_index <= found_r ? INDEX_W'(best_i) : '0;
      direction     <= dir_calc;
    end
  end

endmodule

// ===== design/ntd_checker.sv =====
// Port-level checker for the nearest target direction core, with its bind.
module ntd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic [ntd_pkg::ACTION_W-1:0]  action,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic                          found,
  input logic [ntd_pkg::INDEX_W-1:0]   nearest_index,
  input logic [ntd_pkg::DIR_W-1:0]     direction
);
  import ntd_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(found)
      && $stable(nearest_index) && $stable(direction))
    else $error("result changed while stalled");

  a_not_found_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> nearest_index == '0 && direction == HDG_NONE)
    else $error("empty result carries index or direction");

  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> direction <= HDG_WEST)
    else $error("direction code out of range");

  a_table_op_fast: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (action == ACT_LOAD || action == ACT_LIVE) |=> item_ready)
    else $error("table update did not complete in one cycle");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (action == ACT_INIT || action == ACT_RECALC)
      |=> !item_ready)
    else $error("search transaction did not start the sequencer");

endmodule

bind nearest_target_direction_core ntd_checker u_ntd_checker (.*);

// ===== tb/tb.sv =====
// Testbench for nearest_target_direction_core: random and directed actions checked by a scoreboard.
`timescale 1ns / 1ps

module tb;
  import ntd_pkg::*;

  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 140;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 100;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  idx;
    logic [9:0]          tx;
    logic [9:0]          ty;
    logic                live_bit;
    logic                self_t;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] idx;
    logic [DIR_W-1:0]   dir;
  } answer_t;

  class direction_scoreboard;
    logic [9:0]  node_x, node_y;
    logic [6:0]  count;
    logic [9:0]  tx_mem[64];
    logic [9:0]  ty_mem[64];
    logic [20:0] dsq_mem[64];
    bit          excl[64];
    bit          live[64];
    bit          loaded[64];
    bit          dist_known[64];
    answer_t     pending[$];
    int          errors, results, searches;

    function new();
      node_x = '0;
      node_y = '0;
      count  = '0;
      for (int i = 0; i < 64; i++) begin
        excl[i]       = 1'b0;
        live[i]       = 1'b0;
        loaded[i]     = 1'b0;
        dist_known[i] = 1'b0;
      end
      errors   = 0;
      results  = 0;
      searches = 0;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function int used();
      return (count > 7'd64) ? 64 : int'(count);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [9:0] value);
      case (idx)
        REG_NODE_X:       node_x = value;
        REG_NODE_Y:       node_y = value;
        REG_TARGET_COUNT: count  = value[6:0];
        default: ;
      endcase
    endfunction

    function logic [20:0] span(logic [9:0] a, logic [9:0] b);
      return (a >= b) ? 21'(a - b) : 21'(b - a);
    endfunction

    function logic [DIR_W-1:0] heading(int i);
      logic [20:0] dx, dy;
      dx = span(node_x, tx_mem[i]);
      dy = span(node_y, ty_mem[i]);
      if (dx >= dy) return (node_x < tx_mem[i]) ? HDG_EAST : HDG_WEST;
      return (node_y < ty_mem[i]) ? HDG_SOUTH : HDG_NORTH;
    endfunction

    function bit dist_ready();
      for (int i = 0; i < used(); i++)
        if (!dist_known[i]) return 1'b0;
      return 1'b1;
    endfunction

    function int first_unloaded();
      for (int i = 0; i < used(); i++)
        if (!loaded[i]) return i;
      return -1;
    endfunction

    function void note_item(req_t r);
      int               n, best_i;
      bit               hit;
      logic [LIMIT_W-1:0] best;
      logic [20:0]      dx, dy;
      answer_t          a;
      n      = used();
      best_i = 0;
      hit    = 1'b0;
      a      = '0;
      case (r.action)
        ACT_LOAD: begin
          tx_mem[r.idx] = r.tx;
          ty_mem[r.idx] = r.ty;
          loaded[r.idx] = 1'b1;
        end
        ACT_LIVE: live[r.idx] = r.live_bit;
        ACT_INIT: begin
          best = INIT_LIMIT_SQ;
          for (int i = 0; i < n; i++) begin
            dx = span(node_x, tx_mem[i]);
            dy = span(node_y, ty_mem[i]);
            dsq_mem[i]    = dx * dx + dy * dy;
            excl[i]       = 1'b0;
            dist_known[i] = 1'b1;
            if (LIMIT_W'(dsq_mem[i]) < best) begin
              best   = LIMIT_W'(dsq_mem[i]);
              best_i = i;
              hit    = 1'b1;
            end
          end
          a.found = hit;
          a.idx   = hit ? best_i[INDEX_W-1:0] : '0;
          a.dir   = (hit && dsq_mem[best_i] != 0) ? heading(best_i) : HDG_NONE;
        end
        ACT_RECALC: begin
          if (!r.self_t) begin
            best = RECALC_LIMIT_SQ;
            for (int i = 0; i < n; i++) begin
              if (excl[i] || LIMIT_W'(dsq_mem[i]) >= best) continue;
              if (live[i]) begin
                best   = LIMIT_W'(dsq_mem[i]);
                best_i = i;
                hit    = 1'b1;
              end else begin
                excl[i] = 1'b1;
              end
            end
          end
          a.found = hit;
          a.idx   = hit ? best_i[INDEX_W-1:0] : '0;
          a.dir   = hit ? heading(best_i) : HDG_NONE;
        end
        default: ;
      endcase
      if (r.action == ACT_INIT || r.action == ACT_RECALC) begin
        pending.push_back(a);
        searches++;
      end
    endfunction

    task check_result(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with none expected: found=%0d index=%0d dir=%0d",
                         got.found, got.idx, got.dir));
        return;
      end
      want = pending.pop_front();
      results++;
      if (got.found !== want.found)
        report($sformatf("found %0d, expected %0d", got.found, want.found));
      if (got.idx !== want.idx)
        report($sformatf("nearest_index %0d, expected %0d", got.idx, want.idx));
      if (got.dir !== want.dir)
        report($sformatf("direction %0d, expected %0d", got.dir, want.dir));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [9:0]           cfg_data = '0;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  logic [ACTION_W-1:0]  action = '0;
  logic [INDEX_W-1:0]   entry_index = '0;
  logic [9:0]           target_x = '0;
  logic [9:0]           target_y = '0;
  logic                 is_live = 1'b0;
  logic                 self_is_target = 1'b0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic                 found;
  logic [INDEX_W-1:0]   nearest_index;
  logic [DIR_W-1:0]     direction;

  direction_scoreboard sb;
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int cycles   = 0;
  int items_sent = 0;

  nearest_target_direction_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .action        (action),
    .entry_index   (entry_index),
    .target_x      (target_x),
    .target_y      (target_y),
    .is_live       (is_live),
    .self_is_target(self_is_target),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .found         (found),
    .nearest_index (nearest_index),
    .direction     (direction)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    int stall_cnt;
    stall_cnt = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready)
        sb.check_result('{found: found, idx: nearest_index, dir: direction});
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_cnt = HOLD_CYCLES;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        result_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_cnt = $urandom_range(0, 14);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [9:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic send(req_t r);
    item_valid     <= 1'b1;
    action         <= r.action;
    entry_index    <= r.idx;
    target_x       <= r.tx;
    target_y       <= r.ty;
    is_live        <= r.live_bit;
    self_is_target <= r.self_t;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(r);
    items_sent++;
  endtask

  task automatic send_op(logic [ACTION_W-1:0] act, int idx, int x, int y, bit lv, bit st);
    req_t r;
    r.action   = act;
    r.idx      = idx[INDEX_W-1:0];
    r.tx       = x[9:0];
    r.ty       = y[9:0];
    r.live_bit = lv;
    r.self_t   = st;
    send(r);
  endtask

  task automatic gap();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // drain all results, then let a trailing load or live update complete
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [9:0] pick_coord(logic [9:0] own);
    int t;
    case ($urandom_range(0, 7))
      0: return own;
      1: return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
      2, 3: begin
        t = int'(own) + int'($urandom_range(0, 6)) - 3;
        if (t < 0) t = 0;
        if (t > 1023) t = 1023;
        return t[9:0];
      end
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic req_t make_item();
    req_t r;
    int   n, k, hole;
    n = sb.used();
    k = $urandom_range(0, 99);
    r.idx      = 6'($urandom);
    r.tx       = pick_coord(sb.node_x);
    r.ty       = pick_coord(sb.node_y);
    r.live_bit = 1'($urandom);
    r.self_t   = ($urandom_range(0, 7) == 0);
    if (k < 30) begin
      r.action = ACT_LOAD;
      if (n > 0 && $urandom_range(0, 3) != 0) r.idx = 6'($urandom_range(0, n - 1));
    end else if (k < 60) begin
      r.action   = ACT_LIVE;
      r.live_bit = ($urandom_range(0, 2) != 0);
      if (n > 0 && $urandom_range(0, 3) != 0) r.idx = 6'($urandom_range(0, n - 1));
    end else if (k < 75) begin
      r.action = ACT_INIT;
    end else begin
      r.action = ACT_RECALC;
    end
    // keep searches away from entries with no coordinates or distance yet
    if (r.action == ACT_RECALC && !sb.dist_ready()) r.action = ACT_INIT;
    hole = sb.first_unloaded();
    if (r.action == ACT_INIT && hole >= 0) begin
      r.action = ACT_LOAD;
      r.idx    = hole[INDEX_W-1:0];
    end
    return r;
  endfunction

  initial begin
    logic [9:0] nx, ny, nc;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, self target, ties, sticky exclusion
    put_reg(REG_NODE_X, 10'd100);
    put_reg(REG_NODE_Y, 10'd200);
    put_reg(REG_TARGET_COUNT, 10'd0);
    cfg_write <= 1'b0;
    send_op(ACT_INIT, 0, 0, 0, 0, 0);
    send_op(ACT_RECALC, 0, 0, 0, 0, 0);
    send_op(ACT_RECALC, 0, 0, 0, 0, 1);
    send_op(ACT_LOAD, 0, 100, 200, 0, 0);
    send_op(ACT_LOAD, 1, 110, 200, 0, 0);
    send_op(ACT_LOAD, 2, 90, 205, 0, 0);
    send_op(ACT_LOAD, 3, 100, 230, 0, 0);
    send_op(ACT_LOAD, 4, 103, 190, 0, 0);
    send_op(ACT_LOAD, 5, 0, 0, 0, 0);
    send_op(ACT_LOAD, 6, 1023, 1023, 0, 0);
    send_op(ACT_LOAD, 7, 110, 200, 0, 0);
    send_op(ACT_LOAD, 63, 1023, 0, 0, 0);
    send_op(ACT_LIVE, 1, 0, 0, 1, 0);
    send_op(ACT_LIVE, 7, 0, 0, 1, 0);
    send_op(ACT_LIVE, 3, 0, 0, 1, 0);
    send_op(ACT_LIVE, 4, 0, 0, 1, 0);
    send_op(ACT_LIVE, 63, 0, 0, 1, 0);
    settle();
    put_reg(REG_TARGET_COUNT, 10'd8);
    cfg_write <= 1'b0;
    send_op(ACT_INIT, 0, 0, 0, 0, 0);
    send_op(ACT_RECALC, 0, 0, 0, 0, 0);
    send_op(ACT_RECALC, 0, 0, 0, 0, 1);
    send_op(ACT_LIVE, 0, 0, 0, 1, 0);
    send_op(ACT_RECALC, 0, 0, 0, 0, 0);
    send_op(ACT_LIVE, 1, 0, 0, 0, 0);
    send_op(ACT_RECALC, 0, 0, 0, 0, 0);
    send_op(ACT_INIT, 0, 0, 0, 0, 0);
    send_op(ACT_RECALC, 0, 0, 0, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin nx = 10'd0;    ny = 10'd0;    nc = 10'd1;   end
        1: begin nx = 10'd1023; ny = 10'd1023; nc = 10'd64;  end
        2: begin nx = 10'd0;    ny = 10'd1023; nc = 10'd127; end
        3: begin nx = 10'd1023; ny = 10'd0;    nc = 10'd0;   end
        default: begin
          nx = 10'($urandom);
          ny = 10'($urandom);
          nc = ($urandom_range(0, 3) == 0) ? 10'd64 : 10'($urandom_range(0, 12));
        end
      endcase
      settle();
      put_reg(REG_NODE_X, nx);
      put_reg(REG_NODE_Y, ny);
      put_reg(REG_TARGET_COUNT, nc);
      cfg_write <= 1'b0;
      idle_on = (p != PHASES - 1);
      if (p == 2) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send(make_item());
        gap();
      end
    end
    settle();

    $display("covered %0d transactions, %0d searches, %0d results checked, %0d settings",
             items_sent, sb.searches, sb.results, PHASES + 2);
    $display("incl. empty table, self target, ties, exclusion, %0d-cycle hold", HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== nearest_target_direction_core.f =====
design/ntd_pkg.sv
design/ntd_ram.sv
design/nearest_target_direction_core.sv
design/ntd_checker.sv
tb/tb.sv
